// ===== design/bsss_pkg.sv =====
// Shared types and constants for the blower start/stop sequencer.
package bsss_pkg;

	typedef enum logic [2:0] {
		PH_SLEEP = 3'd0,
		PH_WAIT  = 3'd1,
		PH_START = 3'd2,
		PH_RUN   = 3'd3,
		PH_STOP  = 3'd4,
		PH_FAULT = 3'd5
	} phase_t;

	localparam logic [2:0] REG_NOMINAL_SPEED  = 3'd0;
	localparam logic [2:0] REG_SPINUP_SPEED   = 3'd1;
	localparam logic [2:0] REG_STOPPED_SPEED  = 3'd2;
	localparam logic [2:0] REG_WAIT_DELAY_MS  = 3'd3;
	localparam logic [2:0] REG_START_LIMIT_MS = 3'd4;
	localparam logic [2:0] REG_FAULT_HOLD_MS  = 3'd5;

	localparam logic [15:0] NOMINAL_SPEED_RST  = 16'd3000;
	localparam logic [15:0] SPINUP_SPEED_RST   = 16'd1000;
	localparam logic [15:0] STOPPED_SPEED_RST  = 16'd200;
	localparam logic [15:0] WAIT_DELAY_MS_RST  = 16'd300;
	localparam logic [15:0] START_LIMIT_MS_RST = 16'd10000;
	localparam logic [15:0] FAULT_HOLD_MS_RST  = 16'd5000;

	typedef struct packed {
		logic [15:0] nominal_speed;
		logic [15:0] spinup_speed;
		logic [15:0] stopped_speed;
		logic [15:0] wait_delay_ms;
		logic [15:0] start_limit_ms;
		logic [15:0] fault_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic        run_request;
		logic [15:0] measured_speed;
		logic        drive_error;
		logic [7:0]  elapsed_ms;
	} step_in_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] countdown_ms;
		logic        start_failed;
	} seq_state_t;

	typedef struct packed {
		logic        drive_enable;
		logic [15:0] speed_reference;
	} drive_cmd_t;

endpackage

// ===== design/bsss_step.sv =====
// Combinational next-state and command logic for one control step.
module bsss_step
	import bsss_pkg::*;
(
	input  cfg_t       cfg,
	input  step_in_t   item,
	input  seq_state_t cur,
	output seq_state_t nxt,
	output drive_cmd_t cmd
);

	logic [15:0] cnt_dec;
	logic        expired;

	always_comb begin
		if (cur.countdown_ms > {8'd0, item.elapsed_ms}) begin
			cnt_dec = cur.countdown_ms - {8'd0, item.elapsed_ms};
		end else begin
			cnt_dec = 16'd0;
		end
	end

	assign expired = (cnt_dec == 16'd0);

	always_comb begin
		nxt.phase        = cur.phase;
		nxt.countdown_ms = cnt_dec;
		nxt.start_failed = cur.start_failed;
		case (cur.phase)
			PH_WAIT: begin
				if (expired) begin
					nxt.phase        = PH_START;
					nxt.countdown_ms = cfg.start_limit_ms;
				end
			end
			PH_START: begin
				if (expired) begin
					nxt.phase        = PH_FAULT;
					nxt.start_failed = 1'b1;
					nxt.countdown_ms = cfg.fault_hold_ms;
				end else if (item.measured_speed > cfg.spinup_speed) begin
					nxt.phase        = PH_RUN;
					nxt.start_failed = 1'b0;
				end
			end
			PH_RUN: begin
				if (item.drive_error) begin
					nxt.phase = PH_FAULT;
				end else if (!item.run_request) begin
					nxt.phase = PH_STOP;
				end
			end
			PH_STOP: begin
				if (item.measured_speed < cfg.stopped_speed) begin
					nxt.phase = PH_SLEEP;
				end
			end
			PH_FAULT: begin
				if (!(cur.start_failed && !expired)) begin
					nxt.start_failed = 1'b0;
					if (!item.drive_error) begin
						nxt.phase = PH_SLEEP;
					end
				end
			end
			default: begin
				nxt.phase = PH_SLEEP;
				if (item.run_request) begin
					nxt.phase        = PH_WAIT;
					nxt.countdown_ms = cfg.wait_delay_ms;
				end
			end
		endcase
	end

	always_comb begin
		cmd.drive_enable    = 1'b0;
		cmd.speed_reference = 16'd0;
		case (cur.phase)
			PH_WAIT, PH_STOP: begin
				cmd.drive_enable = 1'b1;
			end
			PH_START, PH_RUN: begin
				cmd.drive_enable    = 1'b1;
				cmd.speed_reference = cfg.nominal_speed;
			end
			default: begin
				cmd.drive_enable    = 1'b0;
				cmd.speed_reference = 16'd0;
			end
		endcase
	end

endmodule

// ===== design/blower_start_stop_sequencer.sv =====
// Top level of the blower start/stop sequencer: registers, handshake and configuration.
// An accepted beat goes from the input register through the step logic into the result register.
// Throughput: one beat per cycle while out_stall does not hold a full result register.
// The input register is stalled only while it holds a beat and the result register is stalled.
// Reset: arst_n clears the state to sleep, the timer and the start-failed flag to zero,
// and loads the configuration registers with their default values.
module blower_start_stop_sequencer
	import bsss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        run_request,
	input  logic [15:0] measured_speed,
	input  logic        drive_error,
	input  logic [7:0]  elapsed_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        drive_enable,
	output logic [15:0] speed_reference,
	output logic [2:0]  phase,
	output logic        start_failed,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	cfg_t       cfg_q;
	step_in_t   item_s1;
	logic       valid_s1;
	seq_state_t state_q;
	seq_state_t state_nxt;
	drive_cmd_t cmd;
	logic       out_valid_q;
	drive_cmd_t cmd_q;
	seq_state_t res_q;
	logic       advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nominal_speed  <= NOMINAL_SPEED_RST;
			cfg_q.spinup_speed   <= SPINUP_SPEED_RST;
			cfg_q.stopped_speed  <= STOPPED_SPEED_RST;
			cfg_q.wait_delay_ms  <= WAIT_DELAY_MS_RST;
			cfg_q.start_limit_ms <= START_LIMIT_MS_RST;
			cfg_q.fault_hold_ms  <= FAULT_HOLD_MS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_NOMINAL_SPEED:  cfg_q.nominal_speed  <= cfg_wdata;
				REG_SPINUP_SPEED:   cfg_q.spinup_speed   <= cfg_wdata;
				REG_STOPPED_SPEED:  cfg_q.stopped_speed  <= cfg_wdata;
				REG_WAIT_DELAY_MS:  cfg_q.wait_delay_ms  <= cfg_wdata;
				REG_START_LIMIT_MS: cfg_q.start_limit_ms <= cfg_wdata;
				REG_FAULT_HOLD_MS:  cfg_q.fault_hold_ms  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.run_request    <= run_request;
			item_s1.measured_speed <= measured_speed;
			item_s1.drive_error    <= drive_error;
			item_s1.elapsed_ms     <= elapsed_ms;
		end
	end

	bsss_step u_step (
		.cfg  (cfg_q),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.cmd  (cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= PH_SLEEP;
			state_q.countdown_ms <= 16'd0;
			state_q.start_failed <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_q <= cmd;
			res_q <= state_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign drive_enable    = cmd_q.drive_enable;
	assign speed_reference = cmd_q.speed_reference;
	assign phase           = res_q.phase;
	assign start_failed    = res_q.start_failed;

`ifndef SYNTHESIS
	a_state_holds_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("Sequencer state changed without a step.");

	a_reference_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (speed_reference != 16'd0) |-> drive_enable)
		else $error("Nonzero speed reference issued with the drive disabled.");

	a_flag_only_in_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_failed |-> (phase == PH_FAULT))
		else $error("Start-failed flag reported outside the fault state.");

	a_step_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("A completed step did not reach the result register.");
`endif

endmodule
